// File: hdl/complex_arith_unit_assert.svh
// assertion macros shared by the complex arithmetic unit
`ifndef COMPLEX_ARITH_UNIT_ASSERT_SVH
`define COMPLEX_ARITH_UNIT_ASSERT_SVH

// property that must hold at every clock edge out of reset
`define CAU_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// same-cycle implication
`define CAU_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// File: hdl/cau_pkg.sv
// shared types and constants of the complex arithmetic unit
package cau_pkg;
	localparam int DATA_WIDTH_DEF = 16;
	localparam int FRAC_BITS_DEF  = 12;
	localparam int MID_DEPTH      = 4;

	typedef enum logic [1:0] {
		CMD_ADD = 2'd0,
		CMD_SUB = 2'd1,
		CMD_MUL = 2'd2,
		CMD_DIV = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_SAT  = 2'd1,
		ST_DIVZ = 2'd2
	} status_t;

	typedef struct packed {
		cmd_t cmd;
		logic equal;
		logic div_zero;
	} ctl_t;

	localparam int CTL_W = $bits(ctl_t);
endpackage

// File: hdl/cau_fifo.sv
// small first-in first-out queue with show-ahead read
module cau_fifo #(
	parameter int W     = 8,
	parameter int DEPTH = 4
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  logic [W-1:0]               wdata,
	input  logic                       pop,
	output logic [W-1:0]               rdata,
	output logic                       full,
	output logic                       empty,
	output logic [$clog2(DEPTH+1)-1:0] count
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH+1);

	logic [W-1:0]  mem_q [DEPTH];
	logic [AW-1:0] wr_q, rd_q;
	logic [CW-1:0] cnt_q;
	logic          do_push, do_pop;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign count   = cnt_q;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == AW'(DEPTH-1)) ? '0 : wr_q + AW'(1);
			end
			if (do_pop) begin
				rd_q <= (rd_q == AW'(DEPTH-1)) ? '0 : rd_q + AW'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end
endmodule

// File: hdl/cau_front.sv
// front end: classifies a word and settles add, subtract, equality and zero divisor
module cau_front #(
	parameter int DW = cau_pkg::DATA_WIDTH_DEF
) (
	input  logic [1:0]           command,
	input  logic signed [DW-1:0] a_re,
	input  logic signed [DW-1:0] a_im,
	input  logic signed [DW-1:0] b_re,
	input  logic signed [DW-1:0] b_im,
	output cau_pkg::ctl_t        ctl,
	output logic [DW-1:0]        as_re,
	output logic [DW-1:0]        as_im,
	output logic                 as_sat
);
	import cau_pkg::*;

	logic signed [DW:0] s_re, s_im;
	logic               sat_re, sat_im;
	logic [DW-1:0]      max_v, min_v;

	assign max_v = {1'b0, {(DW-1){1'b1}}};
	assign min_v = {1'b1, {(DW-1){1'b0}}};

	always_comb begin
		if (cmd_t'(command) == CMD_SUB) begin
			s_re = $signed({a_re[DW-1], a_re}) - $signed({b_re[DW-1], b_re});
			s_im = $signed({a_im[DW-1], a_im}) - $signed({b_im[DW-1], b_im});
		end else begin
			s_re = $signed({a_re[DW-1], a_re}) + $signed({b_re[DW-1], b_re});
			s_im = $signed({a_im[DW-1], a_im}) + $signed({b_im[DW-1], b_im});
		end
	end

	// overflow when the two top bits of the grown sum differ
	assign sat_re = s_re[DW] != s_re[DW-1];
	assign sat_im = s_im[DW] != s_im[DW-1];
	assign as_re  = sat_re ? (s_re[DW] ? min_v : max_v) : s_re[DW-1:0];
	assign as_im  = sat_im ? (s_im[DW] ? min_v : max_v) : s_im[DW-1:0];
	assign as_sat = sat_re || sat_im;

	assign ctl.cmd      = cmd_t'(command);
	assign ctl.equal    = (a_re == b_re) && (a_im == b_im);
	assign ctl.div_zero = (b_re == '0) && (b_im == '0);
endmodule

// File: hdl/cau_back.sv
// back end: products, sums and a pipelined restoring divider, then result select
module cau_back #(
	parameter int DW = cau_pkg::DATA_WIDTH_DEF,
	parameter int FB = cau_pkg::FRAC_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  cau_pkg::ctl_t        in_ctl,
	input  logic signed [DW-1:0] a_re,
	input  logic signed [DW-1:0] a_im,
	input  logic signed [DW-1:0] b_re,
	input  logic signed [DW-1:0] b_im,
	input  logic [DW-1:0]        as_re,
	input  logic [DW-1:0]        as_im,
	input  logic                 as_sat,
	output logic                 out_valid,
	output logic [DW-1:0]        res_re,
	output logic [DW-1:0]        res_im,
	output logic                 equal,
	output logic [1:0]           status
);
	import cau_pkg::*;

	localparam int PW = 2*DW;
	localparam int SW = 2*DW+1;
	localparam int MW = 2*DW;
	localparam int RW = 3*DW+FB;

	typedef struct packed {
		ctl_t          ctl;
		logic [DW-1:0] as_re;
		logic [DW-1:0] as_im;
		logic          as_sat;
	} side_t;

	typedef struct packed {
		side_t         side;
		logic [MW-1:0] den;
		logic          neg_re;
		logic          neg_im;
		logic          ovf_re;
		logic          ovf_im;
		logic [DW-1:0] mul_re;
		logic [DW-1:0] mul_im;
		logic          mul_sat;
	} pipe_t;

	// clamp a sign and magnitude value to the field, top bit is the saturation flag
	function automatic logic [DW:0] clamp_sm(input logic neg, input logic ovf,
			input logic [MW-1:0] q);
		logic [MW-1:0] lim;
		logic [MW-1:0] qc;
		logic          sat;
		lim = neg ? (MW'(1) << (DW-1)) : ((MW'(1) << (DW-1)) - MW'(1));
		sat = ovf || (q > lim);
		qc  = sat ? lim : q;
		clamp_sm = {sat, neg ? (DW'(0) - qc[DW-1:0]) : qc[DW-1:0]};
	endfunction

	// stage 1: products
	logic              v_s1;
	side_t             side_s1;
	logic signed [PW-1:0] prr_s1, pii_s1, pri_s1, pir_s1, pbr_s1, pbi_s1;

	always_ff @(posedge clk) begin
		side_s1 <= '{ctl: in_ctl, as_re: as_re, as_im: as_im, as_sat: as_sat};
		prr_s1  <= a_re * b_re;
		pii_s1  <= a_im * b_im;
		pri_s1  <= a_re * b_im;
		pir_s1  <= a_im * b_re;
		pbr_s1  <= b_re * b_re;
		pbi_s1  <= b_im * b_im;
	end

	// stage 2: sums
	logic              v_s2;
	side_t             side_s2;
	logic signed [SW-1:0] sum_re_s2, sum_im_s2;
	logic [MW-1:0]     den_s2;

	always_ff @(posedge clk) begin
		side_s2 <= side_s1;
		den_s2  <= MW'(pbr_s1) + MW'(pbi_s1);
		if (side_s1.ctl.cmd == CMD_DIV) begin
			sum_re_s2 <= $signed({prr_s1[PW-1], prr_s1}) + $signed({pii_s1[PW-1], pii_s1});
			sum_im_s2 <= $signed({pir_s1[PW-1], pir_s1}) - $signed({pri_s1[PW-1], pri_s1});
		end else begin
			sum_re_s2 <= $signed({prr_s1[PW-1], prr_s1}) - $signed({pii_s1[PW-1], pii_s1});
			sum_im_s2 <= $signed({pri_s1[PW-1], pri_s1}) + $signed({pir_s1[PW-1], pir_s1});
		end
	end

	// stage 3: sign and magnitude, multiply result, divider setup
	logic              neg_re, neg_im;
	logic [SW-1:0]     nsum_re, nsum_im;
	logic [MW-1:0]     mag_re, mag_im;
	logic [RW-1:0]     num_re, num_im, dtop;
	logic [DW:0]       mc_re, mc_im;

	assign neg_re  = sum_re_s2[SW-1];
	assign neg_im  = sum_im_s2[SW-1];
	assign nsum_re = SW'(0) - sum_re_s2;
	assign nsum_im = SW'(0) - sum_im_s2;
	assign mag_re  = neg_re ? nsum_re[MW-1:0] : sum_re_s2[MW-1:0];
	assign mag_im  = neg_im ? nsum_im[MW-1:0] : sum_im_s2[MW-1:0];
	assign num_re  = RW'(mag_re) << FB;
	assign num_im  = RW'(mag_im) << FB;
	assign dtop    = RW'(den_s2) << DW;
	assign mc_re   = clamp_sm(neg_re, 1'b0, mag_re >> FB);
	assign mc_im   = clamp_sm(neg_im, 1'b0, mag_im >> FB);

	logic          v_s3;
	pipe_t         pipe_s3;
	logic [RW-1:0] rem_re_s3, rem_im_s3;

	always_ff @(posedge clk) begin
		pipe_s3.side    <= side_s2;
		pipe_s3.den     <= den_s2;
		pipe_s3.neg_re  <= neg_re;
		pipe_s3.neg_im  <= neg_im;
		// quotient would not fit the field width
		pipe_s3.ovf_re  <= num_re >= dtop;
		pipe_s3.ovf_im  <= num_im >= dtop;
		pipe_s3.mul_re  <= mc_re[DW-1:0];
		pipe_s3.mul_im  <= mc_im[DW-1:0];
		pipe_s3.mul_sat <= mc_re[DW] || mc_im[DW];
		rem_re_s3       <= num_re;
		rem_im_s3       <= num_im;
	end

	// divider: one quotient bit per stage, most significant first
	logic          v_sdiv [DW];
	pipe_t         pipe_sdiv [DW];
	logic [RW-1:0] rem_re_sdiv [DW];
	logic [RW-1:0] rem_im_sdiv [DW];
	logic [DW-1:0] q_re_sdiv [DW];
	logic [DW-1:0] q_im_sdiv [DW];

	for (genvar k = 0; k < DW; k++) begin : g_div
		localparam int I = DW-1-k;
		logic          vin;
		pipe_t         pin;
		logic [RW-1:0] rin_re, rin_im, dsh;
		logic [DW-1:0] qin_re, qin_im;
		logic          ge_re, ge_im;

		if (k == 0) begin : g_first
			assign vin    = v_s3;
			assign pin    = pipe_s3;
			assign rin_re = rem_re_s3;
			assign rin_im = rem_im_s3;
			assign qin_re = '0;
			assign qin_im = '0;
		end else begin : g_next
			assign vin    = v_sdiv[k-1];
			assign pin    = pipe_sdiv[k-1];
			assign rin_re = rem_re_sdiv[k-1];
			assign rin_im = rem_im_sdiv[k-1];
			assign qin_re = q_re_sdiv[k-1];
			assign qin_im = q_im_sdiv[k-1];
		end

		assign dsh   = RW'(pin.den) << I;
		assign ge_re = !pin.ovf_re && (rin_re >= dsh);
		assign ge_im = !pin.ovf_im && (rin_im >= dsh);

		always_ff @(posedge clk) begin
			pipe_sdiv[k]   <= pin;
			rem_re_sdiv[k] <= ge_re ? rin_re - dsh : rin_re;
			rem_im_sdiv[k] <= ge_im ? rin_im - dsh : rin_im;
			q_re_sdiv[k]   <= qin_re | (DW'(ge_re) << I);
			q_im_sdiv[k]   <= qin_im | (DW'(ge_im) << I);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_sdiv[k] <= 1'b0;
			end else begin
				v_sdiv[k] <= vin;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// result select
	pipe_t     last;
	logic [DW:0] dc_re, dc_im;

	assign last  = pipe_sdiv[DW-1];
	assign dc_re = clamp_sm(last.neg_re, last.ovf_re, MW'(q_re_sdiv[DW-1]));
	assign dc_im = clamp_sm(last.neg_im, last.ovf_im, MW'(q_im_sdiv[DW-1]));

	assign out_valid = v_sdiv[DW-1];
	assign equal     = last.side.ctl.equal;

	always_comb begin
		res_re = last.side.as_re;
		res_im = last.side.as_im;
		status = last.side.as_sat ? ST_SAT : ST_OK;
		case (last.side.ctl.cmd)
			CMD_MUL: begin
				res_re = last.mul_re;
				res_im = last.mul_im;
				status = last.mul_sat ? ST_SAT : ST_OK;
			end
			CMD_DIV: begin
				if (last.side.ctl.div_zero) begin
					res_re = '0;
					res_im = '0;
					status = ST_DIVZ;
				end else begin
					res_re = dc_re[DW-1:0];
					res_im = dc_im[DW-1:0];
					status = (dc_re[DW] || dc_im[DW]) ? ST_SAT : ST_OK;
				end
			end
			default: begin
			end
		endcase
	end
endmodule

// File: hdl/complex_arith_unit.sv
// top level of the complex arithmetic unit: front end, word queue, back end, result queue
//
//  channel  handshake      fields
//  input    push / full    command, a_re, a_im, b_re, b_im
//  result   pop / empty    res_re, res_im, equal, status
//
// one word per cycle sustained while the result queue has room; the divider resolves
// one quotient bit per stage
// every command takes the same path, so results leave in order
// the back end issues a word only when the result queue has room for everything in flight,
// so a stalled result side fills the queues and then raises full
// arst_n clears both queues and the pipeline valid bits
`include "complex_arith_unit_assert.svh"

module complex_arith_unit #(
	parameter int DATA_WIDTH = cau_pkg::DATA_WIDTH_DEF,
	parameter int FRAC_BITS  = cau_pkg::FRAC_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	output logic                         full,
	input  logic [1:0]                   command,
	input  logic signed [DATA_WIDTH-1:0] a_re,
	input  logic signed [DATA_WIDTH-1:0] a_im,
	input  logic signed [DATA_WIDTH-1:0] b_re,
	input  logic signed [DATA_WIDTH-1:0] b_im,
	output logic                         empty,
	input  logic                         pop,
	output logic signed [DATA_WIDTH-1:0] res_re,
	output logic signed [DATA_WIDTH-1:0] res_im,
	output logic                         equal,
	output logic [1:0]                   status
);
	import cau_pkg::*;

	localparam int DW        = DATA_WIDTH;
	localparam int LAT       = DW + 3;
	localparam int OUT_DEPTH = LAT + 2;
	localparam int MID_W     = CTL_W + 6*DW + 1;
	localparam int OUT_W     = 2*DW + 3;
	localparam int CW        = $clog2(OUT_DEPTH+1);
	localparam int MCW       = $clog2(MID_DEPTH+1);

	ctl_t          f_ctl;
	logic [DW-1:0] f_as_re, f_as_im;
	logic          f_as_sat;

	cau_front #(.DW(DW)) u_front (
		.command (command),
		.a_re    (a_re),
		.a_im    (a_im),
		.b_re    (b_re),
		.b_im    (b_im),
		.ctl     (f_ctl),
		.as_re   (f_as_re),
		.as_im   (f_as_im),
		.as_sat  (f_as_sat)
	);

	logic [MID_W-1:0] mid_rd;
	logic             mid_empty, issue;
	logic [MCW-1:0]   mid_count;

	cau_fifo #(.W(MID_W), .DEPTH(MID_DEPTH)) u_mid (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  ({f_ctl, a_re, a_im, b_re, b_im, f_as_re, f_as_im, f_as_sat}),
		.pop    (issue),
		.rdata  (mid_rd),
		.full   (full),
		.empty  (mid_empty),
		.count  (mid_count)
	);

	ctl_t          m_ctl;
	logic [DW-1:0] m_a_re, m_a_im, m_b_re, m_b_im, m_as_re, m_as_im;
	logic          m_as_sat;

	assign {m_ctl, m_a_re, m_a_im, m_b_re, m_b_im, m_as_re, m_as_im, m_as_sat} = mid_rd;

	logic          b_valid, b_equal;
	logic [DW-1:0] b_res_re, b_res_im;
	logic [1:0]    b_status;

	cau_back #(.DW(DW), .FB(FRAC_BITS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (issue),
		.in_ctl    (m_ctl),
		.a_re      ($signed(m_a_re)),
		.a_im      ($signed(m_a_im)),
		.b_re      ($signed(m_b_re)),
		.b_im      ($signed(m_b_im)),
		.as_re     (m_as_re),
		.as_im     (m_as_im),
		.as_sat    (m_as_sat),
		.out_valid (b_valid),
		.res_re    (b_res_re),
		.res_im    (b_res_im),
		.equal     (b_equal),
		.status    (b_status)
	);

	logic [OUT_W-1:0] out_rd;
	logic             out_full;
	logic [CW-1:0]    out_count, pend_q;
	logic [CW:0]      used;

	// words in flight plus words waiting must fit the result queue
	assign used  = {1'b0, out_count} + {1'b0, pend_q};
	assign issue = !mid_empty && (used < (CW+1)'(OUT_DEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (issue && !b_valid) begin
			pend_q <= pend_q + CW'(1);
		end else if (b_valid && !issue) begin
			pend_q <= pend_q - CW'(1);
		end
	end

	cau_fifo #(.W(OUT_W), .DEPTH(OUT_DEPTH)) u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (b_valid),
		.wdata  ({b_res_re, b_res_im, b_equal, b_status}),
		.pop    (pop),
		.rdata  (out_rd),
		.full   (out_full),
		.empty  (empty),
		.count  (out_count)
	);

	assign res_re = $signed(out_rd[OUT_W-1 -: DW]);
	assign res_im = $signed(out_rd[3 +: DW]);
	assign equal  = out_rd[2];
	assign status = out_rd[1:0];

	`CAU_ASSERT_IMP(a_no_out_overrun, b_valid, !out_full, "result word lost on full queue")
	`CAU_ASSERT(a_credit_bound, used <= (CW+1)'(OUT_DEPTH), "credit count exceeds queue depth")
	`CAU_ASSERT_IMP(a_retire_pending, b_valid, pend_q != '0, "result with nothing in flight")
	`CAU_ASSERT_IMP(a_issue_has_word, issue, mid_count != '0, "issue from empty word queue")
endmodule

// File: sim/tb_complex_arith_unit.sv
// self-checking testbench of the complex arithmetic unit
`timescale 1ns / 1ps

module tb_complex_arith_unit;
	import cau_pkg::*;

	localparam int DW = 16;
	localparam int FB = 12;
	localparam int N_RANDOM = 1130;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam logic signed [DW-1:0] MAXV = 16'sh7fff;
	localparam logic signed [DW-1:0] MINV = 16'sh8000;

	typedef struct packed {
		logic [1:0] cmd;
		logic signed [DW-1:0] ar;
		logic signed [DW-1:0] ai;
		logic signed [DW-1:0] br;
		logic signed [DW-1:0] bi;
	} operand_word_t;

	typedef struct packed {
		logic signed [DW-1:0] re;
		logic signed [DW-1:0] im;
		logic eq;
		logic [1:0] st;
	} result_word_t;

	typedef struct {
		operand_word_t op;
		bit known;
		result_word_t res;
	} vector_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic full;
	logic [1:0] command = CMD_ADD;
	logic signed [DW-1:0] a_re = '0, a_im = '0, b_re = '0, b_im = '0;
	logic empty;
	logic pop = 1'b0;
	logic signed [DW-1:0] res_re, res_im;
	logic equal;
	logic [1:0] status;

	result_word_t pending_results[$];
	vector_t vectors[$];
	int n_fail = 0;
	int n_checked = 0;
	int idle_cycles = 0;
	bit stim_done = 1'b0;
	bit hold_pop = 1'b0;
	int cmd_count[4] = '{0, 0, 0, 0};
	int st_count[3] = '{0, 0, 0};

	complex_arith_unit u_top (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full),
		.command(command), .a_re(a_re), .a_im(a_im), .b_re(b_re), .b_im(b_im),
		.empty(empty), .pop(pop), .res_re(res_re), .res_im(res_im),
		.equal(equal), .status(status)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// clamp a wide signed value into the result field
	function automatic logic signed [DW-1:0] clamp_part(input logic signed [63:0] v,
			inout bit sat);
		if (v > 64'sd32767) begin
			sat = 1'b1;
			return MAXV;
		end
		if (v < -64'sd32768) begin
			sat = 1'b1;
			return MINV;
		end
		return v[DW-1:0];
	endfunction

	// truncation toward zero, as the hardware does on magnitudes
	function automatic logic signed [63:0] trunc_div(input logic signed [63:0] num,
			input logic signed [63:0] den);
		logic [63:0] mag;
		logic [63:0] q;
		mag = (num < 0) ? -num : num;
		q = mag / den;
		return (num < 0) ? -$signed(q) : $signed(q);
	endfunction

	function automatic result_word_t compute_result(input operand_word_t w);
		result_word_t r;
		bit sat;
		logic signed [63:0] ar, ai, br, bi, pr, pi, den;
		sat = 1'b0;
		ar = w.ar; ai = w.ai; br = w.br; bi = w.bi;
		r.eq = (w.ar == w.br) && (w.ai == w.bi);
		r.st = ST_OK;
		r.re = '0;
		r.im = '0;
		case (w.cmd)
			CMD_ADD: begin
				r.re = clamp_part(ar + br, sat);
				r.im = clamp_part(ai + bi, sat);
			end
			CMD_SUB: begin
				r.re = clamp_part(ar - br, sat);
				r.im = clamp_part(ai - bi, sat);
			end
			CMD_MUL: begin
				pr = ar * br - ai * bi;
				pi = ar * bi + ai * br;
				r.re = clamp_part(trunc_div(pr, 64'sd1 <<< FB), sat);
				r.im = clamp_part(trunc_div(pi, 64'sd1 <<< FB), sat);
			end
			default: begin
				den = br * br + bi * bi;
				if (den == 0) begin
					r.st = ST_DIVZ;
				end else begin
					// numerators fit in 33 signed bits, shifted by 12 still well inside 64
					pr = (ar * br + ai * bi) <<< FB;
					pi = (ai * br - ar * bi) <<< FB;
					r.re = clamp_part(trunc_div(pr, den), sat);
					r.im = clamp_part(trunc_div(pi, den), sat);
				end
			end
		endcase
		if (r.st == ST_OK && sat) r.st = ST_SAT;
		return r;
	endfunction

	function automatic operand_word_t random_word();
		operand_word_t w;
		int k;
		w.cmd = 2'($urandom_range(3));
		w.ar = DW'($urandom); w.ai = DW'($urandom);
		w.br = DW'($urandom); w.bi = DW'($urandom);
		k = $urandom_range(9);
		// small operands keep many results in range, copies hit the equal flag
		if (k < 3) begin
			w.ar = $signed(w.ar) >>> $urandom_range(12);
			w.ai = $signed(w.ai) >>> $urandom_range(12);
			w.br = $signed(w.br) >>> $urandom_range(12);
			w.bi = $signed(w.bi) >>> $urandom_range(12);
		end else if (k == 3) begin
			w.br = w.ar;
			w.bi = w.ai;
		end else if (k == 4) begin
			w.br = '0;
			w.bi = $urandom_range(1) ? '0 : w.bi;
		end
		return w;
	endfunction

	task automatic add_vector(input logic [1:0] c, input int ar, ai, br, bi,
			input bit known = 1'b0, input int rr = 0, ri = 0, eq = 0, st = 0);
		vector_t v;
		v.op = '{c, ar[DW-1:0], ai[DW-1:0], br[DW-1:0], bi[DW-1:0]};
		v.known = known;
		v.res = '{rr[DW-1:0], ri[DW-1:0], eq[0], st[1:0]};
		vectors.push_back(v);
	endtask

	// push stays high across back-to-back words
	task automatic send_word(input operand_word_t w);
		int gap;
		gap = $urandom_range(16);
		if (gap != 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		command <= w.cmd;
		a_re <= w.ar; a_im <= w.ai; b_re <= w.br; b_im <= w.bi;
		do @(posedge clk); while (full);
		pending_results.push_back(compute_result(w));
		cmd_count[w.cmd]++;
	endtask

	// directed table, then random words
	initial begin
		operand_word_t w;
		add_vector(CMD_ADD, 0, 0, 0, 0, 1, 0, 0, 1, ST_OK);
		add_vector(CMD_ADD, 32767, 32767, 32767, 32767, 1, 32767, 32767, 1, ST_SAT);
		add_vector(CMD_ADD, -32768, -32768, -32768, -1, 1, -32768, -32768, 0, ST_SAT);
		add_vector(CMD_SUB, 32767, -32768, -1, 1, 1, 32767, -32768, 0, ST_SAT);
		add_vector(CMD_SUB, -32768, 0, -32768, 0, 1, 0, 0, 1, ST_OK);
		add_vector(CMD_MUL, 4096, 0, 4096, 0, 1, 4096, 0, 1, ST_OK);
		add_vector(CMD_MUL, -32768, -32768, -32768, -32768, 1, 0, 32767, 1, ST_SAT);
		add_vector(CMD_MUL, 32767, 32767, -32768, 32767);
		add_vector(CMD_MUL, -1, 1, 1, 1);
		add_vector(CMD_DIV, 4096, 4096, 0, 0, 1, 0, 0, 0, ST_DIVZ);
		add_vector(CMD_DIV, 0, 0, 0, 0, 1, 0, 0, 1, ST_DIVZ);
		add_vector(CMD_DIV, 4096, 0, 4096, 0, 1, 4096, 0, 1, ST_OK);
		add_vector(CMD_DIV, 32767, -32768, 1, 0, 1, 32767, -32768, 0, ST_SAT);
		add_vector(CMD_DIV, -32768, 32767, -32768, -32768);
		add_vector(CMD_DIV, 1, -1, 32767, 32767);
		add_vector(CMD_DIV, -7, 3, 0, -1);
		add_vector(CMD_SUB, 16'h5555, 16'haaaa, 16'haaaa, 16'h5555);
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (vectors[i]) begin
			send_word(vectors[i].op);
			if (vectors[i].known) begin
				void'(pending_results.pop_back());
				pending_results.push_back(vectors[i].res);
			end
		end
		push <= 1'b0;
		// sender pause until the block has drained
		while (pending_results.size() != 0) @(posedge clk);
		for (int i = 0; i < N_RANDOM; i++) begin
			if (i == 200) hold_pop <= 1'b1;
			w = random_word();
			send_word(w);
		end
		push <= 1'b0;
		stim_done <= 1'b1;
	end

	// long receiver hold-off while the sender keeps pushing
	initial begin
		wait (hold_pop);
		repeat (400) @(posedge clk);
		hold_pop <= 1'b0;
	end

	// receiver: random gaps, compares each accepted word
	initial begin
		result_word_t e;
		int gap;
		@(posedge arst_n);
		forever begin
			gap = $urandom_range(16);
			if ($urandom_range(3) == 0) gap = 0;
			if (gap != 0 || hold_pop) begin
				pop <= 1'b0;
				repeat (gap) @(posedge clk);
				while (hold_pop) @(posedge clk);
			end
			pop <= 1'b1;
			do @(posedge clk); while (empty);
			if (pending_results.size() == 0) begin
				$error("result word with nothing expected");
				n_fail++;
			end else begin
				e = pending_results.pop_front();
				n_checked++;
				if (res_re !== e.re) begin
					$error("res_re expected %0d actual %0d", e.re, res_re); n_fail++;
				end
				if (res_im !== e.im) begin
					$error("res_im expected %0d actual %0d", e.im, res_im); n_fail++;
				end
				if (equal !== e.eq) begin
					$error("equal expected %0d actual %0d", e.eq, equal); n_fail++;
				end
				if (status !== e.st) begin
					$error("status expected %0d actual %0d", e.st, status); n_fail++;
				end
				if (e.st <= ST_DIVZ) st_count[e.st]++;
			end
		end
	end

	// watchdog on cycles without any handshake
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog expired after %0d idle cycles", idle_cycles);
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		wait (stim_done);
		while (pending_results.size() != 0) @(posedge clk);
		repeat (3 * (DW + 4)) @(posedge clk);
		$display("checked %0d words: add %0d sub %0d mul %0d div %0d", n_checked,
			cmd_count[0], cmd_count[1], cmd_count[2], cmd_count[3]);
		$display("status ok %0d saturated %0d divide by zero %0d", st_count[0],
			st_count[1], st_count[2]);
		if (n_fail == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end
endmodule
